### hw/rtl/bdr_pkg.sv
package bdr_pkg;

    localparam int IDX_W  = 6;
    localparam int ADDR_W = 12;
    localparam int FRAC_W = 16;
    localparam int STEP_W = FRAC_W + 1;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_ROUND = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [5:0]  row_a;
        logic [5:0]  row_b;
        logic [5:0]  col_a;
        logic [5:0]  col_b;
        logic [31:0] write_value;
        logic [15:0] random_draw;
    } t_in_word;

    typedef struct packed {
        logic [31:0] read_value;
        logic        read_alive;
        logic [5:0]  surviving_col;
        logic [1:0]  killed_edge;
    } t_out_word;

    // classified command handed from front to back
    typedef struct packed {
        logic [1:0]        operation;
        logic [ADDR_W-1:0] addr0;
        logic [ADDR_W-1:0] addr1;
        logic [ADDR_W-1:0] addr2;
        logic [ADDR_W-1:0] addr3;
        logic [5:0]        col_a;
        logic [5:0]        col_b;
        logic [31:0]       write_value;
        logic [15:0]       random_draw;
    } t_cmd;

endpackage

### hw/rtl/butterfly_dependent_rounding.sv
// A round holds the back end while it issues the four reads, picks and weighs the
// step, does four read-modify-writes and snaps the killed edge.
// Writes can follow one per cycle while the output is not stalled; a read holds
// the back end until its result is loaded. A two-word queue decouples intake.
// After reset a clearing pass over all 4096 addresses sets every alive bit; only
// the front queue takes words meanwhile. Weights are undefined until written.
module butterfly_dependent_rounding import bdr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_word  i_word,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_word o_word
);

    logic w_cv, w_cs, w_busy;
    t_cmd w_cmd;

    bdr_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_word,
        .o_cmd_valid(w_cv), .i_cmd_stall(w_cs), .o_cmd(w_cmd)
    );

    bdr_back u_back (
        .i_clk, .i_rst_n, .i_cmd_valid(w_cv), .o_cmd_stall(w_cs), .i_cmd(w_cmd),
        .o_valid, .i_stall, .o_word, .o_busy(w_busy)
    );

    // a word is only issued to the back end when it is free
    a_issue_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cv && !w_cs) |-> !w_busy) else $error("issue while busy");

    // a result with a nonzero killed edge, which only a round gives, never carries read data
    a_round_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_word.killed_edge != 2'd0) |-> (o_word.read_value == 32'd0))
        else $error("round result carries read data");

endmodule

### hw/rtl/bdr_front.sv
module bdr_front import bdr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_in_word i_word,
    output logic     o_cmd_valid,
    input  logic     i_cmd_stall,
    output t_cmd     o_cmd
);

    // two-entry queue of classified commands
    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd       w_cmd;
    logic       w_push, w_pop;

    always_comb begin
        w_cmd             = '0;
        w_cmd.operation   = i_word.operation;
        w_cmd.addr0       = {i_word.row_a, i_word.col_a};
        w_cmd.addr1       = {i_word.row_b, i_word.col_a};
        w_cmd.addr2       = {i_word.row_b, i_word.col_b};
        w_cmd.addr3       = {i_word.row_a, i_word.col_b};
        w_cmd.col_a       = i_word.col_a;
        w_cmd.col_b       = i_word.col_b;
        w_cmd.write_value = i_word.write_value;
        w_cmd.random_draw = i_word.random_draw;
    end

    assign o_stall     = (r_cnt == 2'd2);
    assign w_push      = i_valid && !o_stall;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign w_pop       = o_cmd_valid && !i_cmd_stall;
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule

### hw/rtl/bdr_back.sv
module bdr_back import bdr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    output logic      o_cmd_stall,
    input  t_cmd      i_cmd,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_word o_word,
    output logic      o_busy
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLEAR = 4'd1;
    localparam logic [3:0] S_RD    = 4'd2;  // issue four reads
    localparam logic [3:0] S_RDW   = 4'd3;  // last read data lands
    localparam logic [3:0] S_MIN   = 4'd4;
    localparam logic [3:0] S_MUL   = 4'd5;
    localparam logic [3:0] S_DEC   = 4'd6;
    localparam logic [3:0] S_UPD   = 4'd7;  // read-modify-write in edge order
    localparam logic [3:0] S_SNAP  = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;
    localparam logic [3:0] S_RDOUT = 4'd10;

    logic [31:0] r_mem [1<<ADDR_W];
    logic        r_alive [1<<ADDR_W];
    logic [31:0] r_rdata;
    logic        r_ralive;

    logic [3:0]        r_st;
    logic [ADDR_W-1:0] r_clr;
    logic [2:0]        r_k;
    t_cmd              r_cmd;
    logic [31:0]       r_w [4];
    logic [STEP_W-1:0] r_up, r_dn;
    logic [1:0]        r_up_i, r_dn_i;
    logic [33:0]       r_lhs, r_rhs;
    logic              r_down;
    logic [STEP_W-1:0] r_step;
    logic [1:0]        r_kill;
    logic              r_ovalid;
    t_out_word         r_oword;

    logic [ADDR_W-1:0] w_addr;
    logic              w_we;
    logic [31:0]       w_wdata;
    logic              w_awe, w_adata;
    logic [1:0]        w_e;
    logic [32:0]       w_sum;
    logic [31:0]       w_new;
    logic [STEP_W-1:0] w_t_up [4];
    logic [STEP_W-1:0] w_t_dn [4];
    logic [STEP_W-1:0] w_bu, w_bd;
    logic [1:0]        w_bui, w_bdi;
    logic [32:0]       w_snap;
    logic              w_out_free;
    logic              w_load;
    logic [ADDR_W-1:0] w_cyc [4];

    assign w_cyc[0] = r_cmd.addr0;
    assign w_cyc[1] = r_cmd.addr1;
    assign w_cyc[2] = r_cmd.addr2;
    assign w_cyc[3] = r_cmd.addr3;

    assign w_out_free  = !r_ovalid || !i_stall;
    assign o_cmd_stall = (r_st != S_IDLE) || !w_out_free;
    assign o_valid     = r_ovalid;
    assign o_word      = r_oword;
    assign o_busy      = (r_st != S_IDLE);

    // result register is loaded this cycle
    assign w_load = ((r_st == S_IDLE) && i_cmd_valid && !o_cmd_stall &&
                     (i_cmd.operation != OP_READ) && (i_cmd.operation != OP_ROUND)) ||
                    (r_st == S_RDOUT) || ((r_st == S_OUT) && w_out_free);

    // edge order 0,2,1,3
    assign w_e = {r_k[0], r_k[1]};

    // min search over the cycle's fractions; lowest edge wins ties
    always_comb begin
        w_bu  = '0;
        w_bd  = '0;
        w_bui = '0;
        w_bdi = '0;
        for (int k = 0; k < 4; k++) begin
            if (k[0]) begin
                w_t_up[k] = {1'b0, r_w[k][FRAC_W-1:0]};
                w_t_dn[k] = STEP_W'(1 << FRAC_W) - {1'b0, r_w[k][FRAC_W-1:0]};
            end else begin
                w_t_up[k] = STEP_W'(1 << FRAC_W) - {1'b0, r_w[k][FRAC_W-1:0]};
                w_t_dn[k] = {1'b0, r_w[k][FRAC_W-1:0]};
            end
        end
        w_bu = w_t_up[0];
        w_bd = w_t_dn[0];
        for (int k = 1; k < 4; k++) begin
            if (w_t_up[k] < w_bu) begin w_bu = w_t_up[k]; w_bui = 2'(k); end
            if (w_t_dn[k] < w_bd) begin w_bd = w_t_dn[k]; w_bdi = 2'(k); end
        end
    end

    // step applied to the current content of one edge, and that content snapped to a whole value
    always_comb begin
        w_sum = '0;
        w_new = r_rdata;
        if (((w_e[0] == 1'b0) != r_down)) begin
            w_sum = {1'b0, r_rdata} + 33'(r_step);
            w_new = w_sum[32] ? 32'hFFFF_FFFF : w_sum[31:0];
        end else begin
            w_sum = {1'b0, r_rdata} - 33'(r_step);
            w_new = w_sum[32] ? 32'd0 : w_sum[31:0];
        end
        w_snap = ({1'b0, r_rdata} + 33'(1 << (FRAC_W - 1)));
        w_snap[FRAC_W-1:0] = '0;
        if (w_snap[32]) w_snap = {1'b0, 16'hFFFF, 16'h0000};
    end

    // memory port control
    always_comb begin
        w_addr  = r_cmd.addr0;
        w_we    = 1'b0;
        w_wdata = r_cmd.write_value;
        w_awe   = 1'b0;
        w_adata = 1'b1;
        case (r_st)
            S_IDLE: begin
                w_addr  = i_cmd.addr0;
                w_we    = i_cmd_valid && !o_cmd_stall && (i_cmd.operation == OP_WRITE);
                w_awe   = w_we;
                w_wdata = i_cmd.write_value;
            end
            S_CLEAR: begin
                w_addr = r_clr;
                w_awe  = 1'b1;
            end
            S_RD:  w_addr = w_cyc[r_k[1:0]];
            S_UPD: begin
                w_addr  = w_cyc[w_e];
                w_we    = r_k[2];
                w_wdata = w_new;
                if (!r_k[2]) w_addr = w_cyc[w_e];
            end
            S_SNAP: begin
                w_addr  = w_cyc[r_kill];
                w_we    = r_k[2];
                w_wdata = w_snap[31:0];
                w_awe   = r_k[2];
                w_adata = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_addr] <= w_wdata;
        if (w_awe) r_alive[w_addr] <= w_adata;
        r_rdata  <= r_mem[w_addr];
        r_ralive <= r_alive[w_addr];
    end

    // result valid: set on load, cleared once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_load) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_CLEAR;
            r_clr    <= '0;
            r_k      <= '0;
        end else begin
            case (r_st)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == '1) r_st <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_cmd_valid && !o_cmd_stall) begin
                        r_cmd <= i_cmd;
                        r_k   <= '0;
                        case (i_cmd.operation)
                            OP_READ:  r_st <= S_RDOUT;
                            OP_ROUND: r_st <= S_RD;
                            default: begin
                                r_oword <= '0;
                            end
                        endcase
                    end
                end
                S_RDOUT: begin
                    r_oword <= '{read_value: r_rdata, read_alive: r_ralive,
                                 surviving_col: '0, killed_edge: '0};
                    r_st    <= S_IDLE;
                end
                S_RD: begin
                    if (r_k != 3'd0) r_w[r_k[1:0] - 2'd1] <= r_rdata;
                    r_k <= r_k + 3'd1;
                    if (r_k == 3'd3) r_st <= S_RDW;
                end
                S_RDW: begin
                    r_w[3] <= r_rdata;
                    r_st   <= S_MIN;
                end
                S_MIN: begin
                    r_up   <= w_bu;
                    r_dn   <= w_bd;
                    r_up_i <= w_bui;
                    r_dn_i <= w_bdi;
                    r_st   <= S_MUL;
                end
                S_MUL: begin
                    r_lhs <= 34'(r_cmd.random_draw) * 34'(18'(r_up) + 18'(r_dn));
                    r_rhs <= 34'(r_dn) * 34'd65535;
                    r_st  <= S_DEC;
                end
                S_DEC: begin
                    r_down <= (r_up != '0 || r_dn != '0) && (r_lhs >= r_rhs);
                    r_st   <= S_UPD;
                    r_k    <= '0;
                end
                S_UPD: begin
                    // k[2]=0 read, k[2]=1 write the same edge
                    if (r_k == 3'd0) begin
                        r_step <= r_down ? r_dn : r_up;
                        r_kill <= r_down ? r_dn_i : r_up_i;
                    end
                    if (r_k[2]) begin
                        if (r_k[1:0] == 2'd3) begin
                            r_st <= S_SNAP;
                            r_k  <= '0;
                        end else begin
                            r_k <= {1'b0, r_k[1:0] + 2'd1};
                        end
                    end else begin
                        r_k <= {1'b1, r_k[1:0]};
                    end
                end
                S_SNAP: begin
                    if (r_k[2]) r_st <= S_OUT;
                    r_k <= 3'd4;
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_oword <= '{read_value: '0, read_alive: 1'b0,
                                     surviving_col: (r_kill[1] == 1'b0) ? r_cmd.col_b
                                                                        : r_cmd.col_a,
                                     killed_edge: r_kill};
                        r_st    <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

endmodule
